### sv/dns_name_label_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// dns_name_label_encoder_top_defines.svh
// Assertion macros used by the label encoder datapath.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_LABEL_ENCODER_TOP_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DNSLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DNSLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dnsle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsle_pkg
// Types and constants of the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnsle_pkg;

  localparam int unsigned STORE_DEPTH = 63;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned CHAR_W      = 8;

  localparam logic [CHAR_W-1:0] DOT_CODE = 8'h2E;
  localparam logic [CHAR_W-1:0] NUL_CODE = 8'h00;
  localparam logic              KIND_END = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_char;     // buffer an ordinary character
    logic start_emit;  // latch end flag, fetch first stored byte
    logic load_len;    // load length word into output register
    logic load_byte;   // load stored byte into output register
    logic clear_label; // label finished, reset count and overflow
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_delim;   // incoming item ends a label
    logic slot_free;  // output register can take a word
    logic count_zero; // label is empty
    logic byte_last;  // current byte is the last of the label
  } sts_t;

endpackage

### sv/dnsle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsle_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dnsle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/dnsle_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsle_dp
// Datapath: label store, count, overflow flag and output register.
// ----------------------------------------------------------------------------
`include "dns_name_label_encoder_top_defines.svh"

module dnsle_dp #(
  parameter int unsigned LIMIT = 63
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dnsle_pkg::cmd_t                     cmd,
  output dnsle_pkg::sts_t                     sts,
  input  logic                                in_kind,
  input  logic [dnsle_pkg::CHAR_W-1:0]        in_char,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [dnsle_pkg::CHAR_W-1:0]        out_byte,
  output logic                                out_last,
  output logic                                out_root,
  output logic                                out_ovf
);

  import dnsle_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              at_end_r, at_end_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0] obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;
  logic              oroot_r, oroot_nxt;
  logic              oovf_r, oovf_nxt;

  logic              ram_we, ram_re;
  logic [CNT_W-1:0]  ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;
  logic              room;
  logic              is_end;

  assign is_end         = (in_kind == KIND_END) || (in_char == NUL_CODE);
  assign sts.is_delim   = is_end || (in_char == DOT_CODE);
  assign sts.slot_free  = !ovalid_r || out_tready;
  assign sts.count_zero = (count_r == '0);
  assign sts.byte_last  = ((idx_r + CNT_W'(1)) == count_r);

  assign room      = (count_r < LIMIT_C);
  assign ram_we    = cmd.wr_char && room;
  // first byte on entry, then prefetch the next one as each byte leaves
  assign ram_re    = cmd.start_emit || (cmd.load_byte && !sts.byte_last);
  assign ram_raddr = cmd.start_emit ? '0 : idx_r + CNT_W'(1);

  dnsle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r),
    .wdata (in_char),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    at_end_nxt = at_end_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r && !out_tready;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    oroot_nxt  = oroot_r;
    oovf_nxt   = oovf_r;
    if (cmd.wr_char) begin
      if (room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.start_emit) begin
      at_end_nxt = is_end;
      idx_nxt    = '0;
    end
    if (cmd.load_len) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = CHAR_W'(count_r);
      olast_nxt  = sts.count_zero;
      oroot_nxt  = at_end_r && sts.count_zero;
      oovf_nxt   = ovf_r;
    end
    if (cmd.load_byte) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = ram_rdata;
      olast_nxt  = sts.byte_last;
      oroot_nxt  = at_end_r && sts.byte_last;
      oovf_nxt   = ovf_r;
      idx_nxt    = idx_r + CNT_W'(1);
    end
    if (cmd.clear_label) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    at_end_r <= at_end_nxt;
    idx_r    <= idx_nxt;
    obyte_r  <= obyte_nxt;
    olast_r  <= olast_nxt;
    oroot_r  <= oroot_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_byte   = obyte_r;
  assign out_last   = olast_r;
  assign out_root   = oroot_r;
  assign out_ovf    = oovf_r;

  `DNSLE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= LIMIT_C, "label count beyond limit")
  `DNSLE_ASSERT_NOW(a_ovf_full, ovf_r, count_r == LIMIT_C, "overflow set on a label not full")
  `DNSLE_ASSERT_NOW(a_load_free, cmd.load_len || cmd.load_byte, sts.slot_free,
                    "output register overwritten while held")
  `DNSLE_ASSERT_NEXT(a_clear_done, cmd.clear_label, count_r == '0 && !ovf_r,
                     "label state not cleared after emission")

endmodule

### sv/dnsle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsle_ctrl
// Controller: accepts items, sequences length word and label bytes.
// ----------------------------------------------------------------------------
module dnsle_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  dnsle_pkg::sts_t sts,
  output dnsle_pkg::cmd_t cmd
);

  import dnsle_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LEN  = 2'd1;
  localparam logic [1:0] S_BYTE = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (sts.is_delim) begin
            cmd.start_emit = 1'b1;
            state_nxt      = S_LEN;
          end else begin
            cmd.wr_char = 1'b1;
          end
        end
      end
      S_LEN: begin
        if (sts.slot_free) begin
          cmd.load_len = 1'b1;
          if (sts.count_zero) begin
            cmd.clear_label = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            state_nxt = S_BYTE;
          end
        end
      end
      S_BYTE: begin
        if (sts.slot_free) begin
          cmd.load_byte = 1'b1;
          if (sts.byte_last) begin
            cmd.clear_label = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/dns_name_label_encoder_top.sv
// Input: an ordinary character is taken and gives no word; a dot or end of name moves
//   the controller to S_LEN, which loads the length word once the output register is free.
// Output: a label's length word and bytes leave one word a cycle while out_tready is high,
//   set by the single output register and store read port; no new item is taken until the label is emitted.
// Reset: synchronous, active low; clears count, overflow, state and output valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_top
// Encodes a dotted host name into DNS wire form, one label at a time.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_top #(
  parameter int unsigned MAX_LABEL = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  // input words: one name character or an end marker
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tuser,   // [0] kind (1 = end of name)
  // output words: length byte or label byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // run_last
  output logic [1:0] out_tuser   // [0] root_zero_follows, [1] label_overflow
);

  import dnsle_pkg::*;

  // clamp the label limit to the store depth, and to at least one character
  localparam int unsigned LIMIT = (MAX_LABEL > STORE_DEPTH) ? STORE_DEPTH :
                                  (MAX_LABEL < 1) ? 1 : MAX_LABEL;

  cmd_t cmd;
  sts_t sts;

  // controller: accept items, step through length word and stored bytes
  dnsle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: hold the label, drive the output register
  dnsle_dp #(
    .LIMIT (LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_char    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_root   (out_tuser[0]),
    .out_ovf    (out_tuser[1])
  );

endmodule
